// ----- rtl/sha1_message_digest_macros.svh -----
// Assertion helpers for the SHA-1 digest block.
// Both forms expect clk_i and rst_ni in scope.
`ifndef SHA1_MESSAGE_DIGEST_MACROS_SVH
`define SHA1_MESSAGE_DIGEST_MACROS_SVH

`ifndef SYNTHESIS
`define SHA1_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SHA1_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define SHA1_ASSERT(label, prop, msg)
`define SHA1_NEVER(label, cond, msg)
`endif

`endif

// ----- rtl/sha1_pkg.sv -----
package sha1_pkg;

  localparam int unsigned NumChain  = 5;
  localparam int unsigned NumSched  = 16;
  localparam int unsigned NumRounds = 80;
  localparam int unsigned CountW    = 61;

  localparam logic [31:0] Iv [NumChain] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  localparam logic [7:0] PadByte = 8'h80;

  typedef enum logic [1:0] {
    PH_CH  = 2'd0,
    PH_PAR = 2'd1,
    PH_MAJ = 2'd2,
    PH_PAR2 = 2'd3
  } sha1_phase_e;

  function automatic logic [31:0] sha1_k(sha1_phase_e ph);
    logic [31:0] k;
    case (ph)
      PH_CH:   k = 32'h5a827999;
      PH_PAR:  k = 32'h6ed9eba1;
      PH_MAJ:  k = 32'h8f1bbcdc;
      default: k = 32'hca62c1d6;
    endcase
    return k;
  endfunction

  // controller -> datapath
  typedef struct packed {
    logic take_byte;  // accepted beat carries a byte
    logic pad_push;   // push the word holding the 0x80 marker
    logic fill_push;  // push a zero or length word
    logic fill_len;   // length words go into this block
    logic load_vars;  // a..e <= chain
    logic round;      // one compression round
    logic add_chain;  // chain += a..e
    logic emit_next;  // advance output word index
    logic finish;     // back to initial chain, zero count
  } sha1_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic blk_end;    // next byte completes the block
    logic len_fits;   // length fits after the marker word
    logic widx_last;  // next push fills the block
    logic round_last;
    logic word_last;
  } sha1_stat_t;

endpackage

// ----- rtl/sha1_ctrl.sv -----
module sha1_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                byte_present_i,
  input  logic                last_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  sha1_pkg::sha1_stat_t stat_i,
  output sha1_pkg::sha1_cmd_t  cmd_o
);
  import sha1_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PAD  = 6'b000010,
    ST_FILL = 6'b000100,
    ST_RUN  = 6'b001000,
    ST_ADD  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   pad_pend_q, pad_pend_d;
  logic   closing_q, closing_d;
  logic   len_ok_q, len_ok_d;
  logic   in_acc;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign in_acc      = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    pad_pend_d = pad_pend_q;
    closing_d  = closing_q;
    len_ok_d   = len_ok_q;
    cmd_o      = '0;
    cmd_o.fill_len = len_ok_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (byte_present_i) begin
            cmd_o.take_byte = 1'b1;
            if (stat_i.blk_end) begin
              cmd_o.load_vars = 1'b1;
              pad_pend_d      = last_i;
              state_d         = ST_RUN;
            end else if (last_i) begin
              state_d = ST_PAD;
            end
          end else if (last_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd_o.pad_push = 1'b1;
        closing_d      = 1'b1;
        len_ok_d       = stat_i.len_fits;
        if (stat_i.widx_last) begin
          cmd_o.load_vars = 1'b1;
          state_d         = ST_RUN;
        end else begin
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        cmd_o.fill_push = 1'b1;
        if (stat_i.widx_last) begin
          cmd_o.load_vars = 1'b1;
          state_d         = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.round = 1'b1;
        if (stat_i.round_last) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd_o.add_chain = 1'b1;
        if (pad_pend_q) begin
          pad_pend_d = 1'b0;
          state_d    = ST_PAD;
        end else if (!closing_q) begin
          state_d = ST_IDLE;
        end else if (len_ok_q) begin
          state_d = ST_OUT;
        end else begin
          // marker block was full; length goes in a second block
          len_ok_d = 1'b1;
          state_d  = ST_FILL;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          if (stat_i.word_last) begin
            cmd_o.finish = 1'b1;
            closing_d    = 1'b0;
            len_ok_d     = 1'b0;
            state_d      = ST_IDLE;
          end else begin
            cmd_o.emit_next = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pad_pend_q <= 1'b0;
      closing_q  <= 1'b0;
      len_ok_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      pad_pend_q <= pad_pend_d;
      closing_q  <= closing_d;
      len_ok_q   <= len_ok_d;
    end
  end

endmodule

// ----- rtl/sha1_dp.sv -----
module sha1_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          data_byte_i,
  input  sha1_pkg::sha1_cmd_t  cmd_i,
  output sha1_pkg::sha1_stat_t stat_o,
  output logic [31:0]         digest_word_o,
  output logic [2:0]          word_index_o,
  output logic                last_word_o
);
  import sha1_pkg::*;

  logic [31:0]       chain_q [NumChain];
  logic [31:0]       vars_q  [NumChain];
  logic [31:0]       sched_q [NumSched];
  logic [31:0]       word_q, word_d;
  logic [CountW-1:0] count_q;
  logic [3:0]        widx_q;
  logic [6:0]        rnd_q;
  logic [2:0]        oidx_q;

  logic [1:0]  pos;
  logic [31:0] byte_word, pad_word, fill_word, sched_new, sched_in;
  logic [31:0] f_val, tmp;
  logic        push;
  sha1_phase_e phase;

  function automatic logic [31:0] put_byte(logic [31:0] w, logic [1:0] p, logic [7:0] b);
    logic [31:0] base;
    logic [31:0] sh;
    base = (p == 2'd0) ? 32'd0 : w;
    sh   = {24'd0, b} << {~p, 3'b000};
    return base | sh;
  endfunction

  function automatic logic [31:0] rotl(logic [31:0] x, int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  assign pos       = count_q[1:0];
  assign byte_word = put_byte(word_q, pos, data_byte_i);
  assign pad_word  = put_byte(word_q, pos, PadByte);

  // bit length = count * 8, split into the two trailing words
  always_comb begin
    fill_word = 32'd0;
    if (cmd_i.fill_len && widx_q == 4'd14) begin
      fill_word = count_q[CountW-1:CountW-32];
    end else if (cmd_i.fill_len && widx_q == 4'd15) begin
      fill_word = {count_q[CountW-33:0], 3'b000};
    end
  end

  assign sched_new = rotl(sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0], 1);

  always_comb begin
    push     = 1'b0;
    sched_in = sched_new;
    word_d   = word_q;
    if (cmd_i.take_byte) begin
      word_d   = byte_word;
      push     = (pos == 2'd3);
      sched_in = byte_word;
    end else if (cmd_i.pad_push) begin
      push     = 1'b1;
      sched_in = pad_word;
    end else if (cmd_i.fill_push) begin
      push     = 1'b1;
      sched_in = fill_word;
    end else if (cmd_i.round) begin
      push     = 1'b1;
    end
  end

  always_comb begin
    if (rnd_q inside {[7'd0:7'd19]}) begin
      phase = PH_CH;
    end else if (rnd_q inside {[7'd20:7'd39]}) begin
      phase = PH_PAR;
    end else if (rnd_q inside {[7'd40:7'd59]}) begin
      phase = PH_MAJ;
    end else begin
      phase = PH_PAR2;
    end
    case (phase)
      PH_CH:   f_val = (vars_q[1] & vars_q[2]) | (~vars_q[1] & vars_q[3]);
      PH_MAJ:  f_val = (vars_q[1] & vars_q[2]) | (vars_q[1] & vars_q[3])
                     | (vars_q[2] & vars_q[3]);
      default: f_val = vars_q[1] ^ vars_q[2] ^ vars_q[3];
    endcase
  end

  assign tmp = rotl(vars_q[0], 5) + f_val + vars_q[4] + sha1_k(phase) + sched_q[0];

  // schedule, assembly word and working variables
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    if (push) begin
      for (int i = 0; i < NumSched - 1; i++) begin
        sched_q[i] <= sched_q[i+1];
      end
      sched_q[NumSched-1] <= sched_in;
    end
    if (cmd_i.load_vars) begin
      vars_q <= chain_q;
    end else if (cmd_i.round) begin
      vars_q[0] <= tmp;
      vars_q[1] <= vars_q[0];
      vars_q[2] <= rotl(vars_q[1], 30);
      vars_q[3] <= vars_q[2];
      vars_q[4] <= vars_q[3];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= Iv;
      count_q <= '0;
      widx_q  <= '0;
      rnd_q   <= '0;
      oidx_q  <= '0;
    end else begin
      if (cmd_i.take_byte) begin
        count_q <= count_q + CountW'(1);
      end
      if (push && !cmd_i.round) begin
        widx_q <= widx_q + 4'd1;
      end
      if (cmd_i.round) begin
        rnd_q <= stat_o.round_last ? 7'd0 : rnd_q + 7'd1;
      end
      if (cmd_i.add_chain) begin
        for (int i = 0; i < NumChain; i++) begin
          chain_q[i] <= chain_q[i] + vars_q[i];
        end
      end
      if (cmd_i.emit_next) begin
        oidx_q <= oidx_q + 3'd1;
      end
      if (cmd_i.finish) begin
        chain_q <= Iv;
        count_q <= '0;
        widx_q  <= '0;
        oidx_q  <= '0;
      end
    end
  end

  assign stat_o.blk_end    = (count_q[5:0] == 6'd63);
  assign stat_o.len_fits   = (count_q[5:0] < 6'd56);
  assign stat_o.widx_last  = (widx_q == 4'd15);
  assign stat_o.round_last = (rnd_q == 7'(NumRounds - 1));
  assign stat_o.word_last  = (oidx_q == 3'(NumChain - 1));

  always_comb begin
    case (oidx_q)
      3'd0:    digest_word_o = chain_q[0];
      3'd1:    digest_word_o = chain_q[1];
      3'd2:    digest_word_o = chain_q[2];
      3'd3:    digest_word_o = chain_q[3];
      default: digest_word_o = chain_q[4];
    endcase
  end

  assign word_index_o = oidx_q;
  assign last_word_o  = stat_o.word_last;

endmodule

// ----- rtl/sha1_message_digest.sv -----
// Channel  Dir  Handshake                 Beat
// in       in   in_valid_i / in_ready_o    data_byte_i, byte_present_i, last_i
// out      out  out_valid_o / out_ready_i  digest_word_o, word_index_o, last_word_o
//
// A byte beat that fills a 64-byte block starts the 80 rounds and the chain add. A last beat
// adds the 0x80 marker word and fill words (zeros, then the length), then the rounds and
// chain add; if the length does not fit, a second final block of fill words, its rounds
// and chain add follow. Five output beats follow; no input is taken until they leave.
// Reset is asynchronous, active low; the chain starts at the SHA-1 initial values.
// Output beats hold while out_ready_i is low.
`include "sha1_message_digest_macros.svh"

module sha1_message_digest (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  import sha1_pkg::*;

  sha1_cmd_t  cmd;
  sha1_stat_t stat;

  sha1_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .byte_present_i (byte_present_i),
    .last_i         (last_i),
    .in_ready_o     (in_ready_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .stat_i         (stat),
    .cmd_o          (cmd)
  );

  sha1_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .data_byte_i   (data_byte_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .last_word_o   (last_word_o)
  );

  `SHA1_NEVER(a_no_overlap, in_ready_o && out_valid_o, "input and output open together")
  `SHA1_ASSERT(a_one_shift_src, $onehot0({cmd.take_byte, cmd.pad_push, cmd.fill_push, cmd.round}), "schedule written from two sources")
  `SHA1_ASSERT(a_idle_after_digest, (out_valid_o && out_ready_i && last_word_o) |=> in_ready_o, "not idle after last digest word")

endmodule

// ----- dv/tb.sv -----
module tb;
  import sha1_pkg::*;

  localparam int unsigned LimitCycles = 600000;
  localparam int unsigned TailCycles  = 400;

  localparam logic [31:0] KRound0 = 32'h5a827999;
  localparam logic [31:0] KRound1 = 32'h6ed9eba1;
  localparam logic [31:0] KRound2 = 32'h8f1bbcdc;
  localparam logic [31:0] KRound3 = 32'hca62c1d6;
  localparam logic [31:0] ChainInit [5] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };
  localparam logic [7:0] MarkerByte = 8'h80;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        final_word;
  } digest_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic [7:0] data_byte_i;
  logic byte_present_i;
  logic last_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [31:0] digest_word_o;
  logic [2:0] word_index_o;
  logic last_word_o;

  sha1_message_digest DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .byte_present_i(byte_present_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .last_word_o   (last_word_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  logic [31:0] sha_chain [5];
  logic [31:0] sha_sched [16];
  logic [60:0] sha_bytes;

  digest_beat_t digest_words_q [$];

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  function automatic logic [31:0] rotl32(logic [31:0] x, int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic compress_model();
    logic [31:0] a, b, c, d, e, f, k, w, tmp;
    sha1_phase_e ph;
    a = sha_chain[0];
    b = sha_chain[1];
    c = sha_chain[2];
    d = sha_chain[3];
    e = sha_chain[4];
    for (int t = 0; t < 80; t++) begin
      if (t >= 16) begin
        w = sha_sched[(t + 13) % 16] ^ sha_sched[(t + 8) % 16]
          ^ sha_sched[(t + 2) % 16] ^ sha_sched[t % 16];
        sha_sched[t % 16] = rotl32(w, 1);
      end
      w = sha_sched[t % 16];
      ph = sha1_phase_e'(t / 20);
      case (ph)
        PH_CH: begin
          f = (b & c) | (~b & d);
          k = KRound0;
        end
        PH_PAR: begin
          f = b ^ c ^ d;
          k = KRound1;
        end
        PH_MAJ: begin
          f = (b & c) | (b & d) | (c & d);
          k = KRound2;
        end
        default: begin
          f = b ^ c ^ d;
          k = KRound3;
        end
      endcase
      tmp = rotl32(a, 5) + f + e + k + w;
      e = d;
      d = c;
      c = rotl32(b, 30);
      b = a;
      a = tmp;
    end
    sha_chain[0] += a;
    sha_chain[1] += b;
    sha_chain[2] += c;
    sha_chain[3] += d;
    sha_chain[4] += e;
  endtask

  // big-endian byte placement; offset 0 of a word starts it fresh
  task automatic place_byte(int unsigned pos, logic [7:0] v);
    int unsigned wi;
    int unsigned sh;
    wi = pos / 4;
    sh = (3 - pos % 4) * 8;
    if (pos % 4 == 0) begin
      sha_sched[wi] = {24'h0, v} << sh;
    end else begin
      sha_sched[wi] |= {24'h0, v} << sh;
    end
  endtask

  task automatic predict_digest_beat(logic [7:0] data_v, logic present, logic closes);
    int unsigned pos;
    logic [63:0] bits;
    digest_beat_t exp_beat;
    if (present) begin
      place_byte(32'(sha_bytes[5:0]), data_v);
      sha_bytes = sha_bytes + 61'd1;
      if (sha_bytes[5:0] == 6'd0) compress_model();
    end
    if (closes) begin
      pos = 32'(sha_bytes[5:0]);
      place_byte(pos, MarkerByte);
      for (int i = pos / 4 + 1; i < 16; i++) sha_sched[i] = 32'h0;
      // no room for the length: extra final block
      if (pos >= 56) begin
        compress_model();
        for (int i = 0; i < 16; i++) sha_sched[i] = 32'h0;
      end
      bits = {sha_bytes, 3'b000};
      sha_sched[14] = bits[63:32];
      sha_sched[15] = bits[31:0];
      compress_model();
      for (int i = 0; i < 5; i++) begin
        exp_beat.word = sha_chain[i];
        exp_beat.index = 3'(i);
        exp_beat.final_word = (i == 4);
        digest_words_q.push_back(exp_beat);
      end
      for (int i = 0; i < 5; i++) sha_chain[i] = ChainInit[i];
      sha_bytes = '0;
    end
  endtask

  task automatic send_beat(logic [7:0] data_v, logic present, logic closes);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= data_v;
    byte_present_i <= present;
    last_i <= closes;
    do @(posedge clk_i); while (!in_ready_o);
    predict_digest_beat(data_v, present, closes);
  endtask

  task automatic wait_digests_drained();
    while (digest_words_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    digest_beat_t exp_beat;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (digest_words_q.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected digest beat: word %h index %0d last %b",
                 $time, digest_word_o, word_index_o, last_word_o);
      end else begin
        exp_beat = digest_words_q.pop_front();
        if (digest_word_o !== exp_beat.word) begin
          mismatch_count++;
          $display("%0t digest_word: expected %h, actual %h",
                   $time, exp_beat.word, digest_word_o);
        end
        if (word_index_o !== exp_beat.index) begin
          mismatch_count++;
          $display("%0t word_index: expected %0d, actual %0d",
                   $time, exp_beat.index, word_index_o);
        end
        if (last_word_o !== exp_beat.final_word) begin
          mismatch_count++;
          $display("%0t last_word: expected %b, actual %b",
                   $time, exp_beat.final_word, last_word_o);
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LimitCycles) begin
      $display("%0t timeout, %0d digest beats outstanding", $time, digest_words_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic test_empty_message();
    send_beat(8'hff, 1'b0, 1'b1);
    // second one checks the chain went back to its start values
    send_beat(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_byte_with_last();
    send_beat("a", 1'b1, 1'b0);
    send_beat("b", 1'b1, 1'b0);
    send_beat("c", 1'b1, 1'b1);
    send_beat(8'h5a, 1'b1, 1'b1);
  endtask

  task automatic test_field_extremes();
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hff, 1'b0, 1'b0);
    send_beat(8'hff, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'h80, 1'b1, 1'b0);
    send_beat(8'h7f, 1'b1, 1'b0);
    send_beat(8'h00, 1'b1, 1'b1);
  endtask

  task automatic test_drain_pause();
    send_beat(8'h31, 1'b1, 1'b0);
    send_beat(8'h32, 1'b1, 1'b1);
    in_valid_i <= 1'b0;
    wait_digests_drained();
    repeat (20) @(posedge clk_i);
    send_beat(8'hc3, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_random_messages(int unsigned sender_idle, int unsigned recv_stall,
                                      int unsigned target);
    int unsigned sent;
    int unsigned len;
    logic tail_byte;
    idle_pct = sender_idle;
    stall_pct = recv_stall;
    sent = 0;
    while (sent < target) begin
      case ($urandom_range(15))
        10, 11: len = $urandom_range(55, 56);
        12, 13: len = $urandom_range(63, 65);
        14: len = $urandom_range(119, 120);
        15: len = $urandom_range(20, 50);
        default: len = $urandom_range(12);
      endcase
      tail_byte = (len != 0) && ($urandom_range(1) == 1);
      for (int i = 0; i < len; i++) begin
        // occasional empty beat, ignored by the block
        if ($urandom_range(19) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
        send_beat(8'($urandom), 1'b1, tail_byte && (i == len - 1));
        sent++;
      end
      if (!tail_byte) begin
        send_beat(8'($urandom), 1'b0, 1'b1);
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    data_byte_i <= 8'h00;
    byte_present_i <= 1'b0;
    last_i <= 1'b0;
    out_ready_i <= 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    mismatch_count = 0;
    cycle_count = 0;
    for (int i = 0; i < 5; i++) sha_chain[i] = ChainInit[i];
    for (int i = 0; i < 16; i++) sha_sched[i] = 32'h0;
    sha_bytes = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_message();
    test_byte_with_last();
    test_field_extremes();
    test_drain_pause();
    test_random_messages(0, 0, 75);
    test_random_messages(78, 0, 75);
    test_random_messages(0, 78, 75);
    test_random_messages(7, 7, 75);

    in_valid_i <= 1'b0;
    wait_digests_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0 && digest_words_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
